// ----- design/nearest_palette_color_macros.svh -----
// assertion helpers used by the top-level design file
`ifndef NEAREST_PALETTE_COLOR_MACROS_SVH
`define NEAREST_PALETTE_COLOR_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define NPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("nearest_palette_color assertion failed");

// next-cycle implication, disabled while reset is asserted
`define NPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("nearest_palette_color assertion failed");

`endif

// ----- design/npc_pkg.sv -----
`default_nettype none

package npc_pkg;

	// palette table size and default number of compared entries
	localparam int unsigned TABLE_SIZE          = 16;
	localparam int unsigned PALETTE_ENTRIES_DEF = 16;

	// widths of a distance and of an index
	localparam int unsigned DIST_W = 20;
	localparam int unsigned IDX_W  = 4;

	typedef logic [DIST_W-1:0] dist_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [7:0]        chan_t;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} rgb_t;

	// one comparison candidate
	typedef struct packed {
		dist_t wdist;
		idx_t  idx;
	} cand_t;

	// registered result of the search
	typedef struct packed {
		idx_t idx;
		logic poor;
	} res_t;

	// poor-match threshold (sum of weights times 64 squared)
	localparam dist_t POOR_LIMIT = DIST_W'((2 + 3 + 4) * 64 * 64);

	// distance for entries that take no part; above any real distance
	localparam dist_t DIST_PAD = '1;

	// fixed palette
	localparam rgb_t PALETTE [TABLE_SIZE] = '{
		'{8'd0,   8'd0,   8'd0},   '{8'd255, 8'd255, 8'd255},
		'{8'd136, 8'd0,   8'd0},   '{8'd170, 8'd255, 8'd238},
		'{8'd204, 8'd68,  8'd204}, '{8'd0,   8'd204, 8'd85},
		'{8'd0,   8'd0,   8'd170}, '{8'd238, 8'd238, 8'd119},
		'{8'd221, 8'd136, 8'd85},  '{8'd102, 8'd68,  8'd0},
		'{8'd255, 8'd119, 8'd119}, '{8'd51,  8'd51,  8'd51},
		'{8'd119, 8'd119, 8'd119}, '{8'd170, 8'd255, 8'd102},
		'{8'd0,   8'd136, 8'd255}, '{8'd187, 8'd187, 8'd187}
	};

	// absolute difference of two channel values
	function automatic chan_t abs_diff(input chan_t a, input chan_t b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	// keep the lower-index candidate a unless b is strictly closer
	function automatic cand_t pick_best(input cand_t a, input cand_t b);
		return (b.wdist < a.wdist) ? b : a;
	endfunction

endpackage

`default_nettype wire

// ----- design/npc_dist_lane.sv -----
`default_nettype none

module npc_dist_lane #(
	parameter int unsigned ENTRY = 0
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire npc_pkg::chan_t red,
	input  wire npc_pkg::chan_t green,
	input  wire npc_pkg::chan_t blue,
	output npc_pkg::dist_t      wdist
);

	localparam npc_pkg::rgb_t REF = npc_pkg::PALETTE[ENTRY];

	npc_pkg::chan_t dr_s1, dg_s1, db_s1;
	logic [15:0]    sr_s2, sg_s2, sb_s2;
	npc_pkg::dist_t dist_s3;

	// channel differences
	always_ff @(posedge clk) begin
		if (en) begin
			dr_s1 <= npc_pkg::abs_diff(red, REF.red);
			dg_s1 <= npc_pkg::abs_diff(green, REF.green);
			db_s1 <= npc_pkg::abs_diff(blue, REF.blue);
		end
	end

	// squares
	always_ff @(posedge clk) begin
		if (en) begin
			sr_s2 <= 16'(dr_s1 * dr_s1);
			sg_s2 <= 16'(dg_s1 * dg_s1);
			sb_s2 <= 16'(db_s1 * db_s1);
		end
	end

	// weighted sum 2*r + 4*g + 3*b
	always_ff @(posedge clk) begin
		if (en) begin
			dist_s3 <= {3'b000, sr_s2, 1'b0} + {2'b00, sg_s2, 2'b00}
				+ {3'b000, sb_s2, 1'b0} + {4'b0000, sb_s2};
		end
	end

	assign wdist = dist_s3;

endmodule

`default_nettype wire

// ----- design/npc_min_tree.sv -----
`default_nettype none

module npc_min_tree (
	input  wire logic           clk,
	input  wire logic           en,
	input  wire npc_pkg::cand_t cand [npc_pkg::TABLE_SIZE],
	output npc_pkg::res_t       res
);

	localparam int unsigned QUADS = npc_pkg::TABLE_SIZE / 4;

	npc_pkg::cand_t quad_s4 [QUADS];
	npc_pkg::cand_t best;
	npc_pkg::res_t  res_s5;

	// first two levels: best of each group of four
	always_ff @(posedge clk) begin
		if (en) begin
			for (int q = 0; q < QUADS; q++) begin
				quad_s4[q] <= npc_pkg::pick_best(
					npc_pkg::pick_best(cand[4*q], cand[4*q+1]),
					npc_pkg::pick_best(cand[4*q+2], cand[4*q+3]));
			end
		end
	end

	// last two levels
	always_comb begin
		best = npc_pkg::pick_best(
			npc_pkg::pick_best(quad_s4[0], quad_s4[1]),
			npc_pkg::pick_best(quad_s4[2], quad_s4[3]));
	end

	// result register with the threshold flag
	always_ff @(posedge clk) begin
		if (en) begin
			res_s5.idx  <= best.idx;
			res_s5.poor <= (best.wdist > npc_pkg::POOR_LIMIT);
		end
	end

	assign res = res_s5;

endmodule

`default_nettype wire

// ----- design/nearest_palette_color.sv -----
// Nearest palette color: each transfer on the pixel channel carries one RGB pixel and
// yields exactly one result: the index of the closest of the fixed 16 palette entries
// under the distance 2*dr^2 + 4*dg^2 + 3*db^2 (lowest index on a tie), and poor_match,
// set when that best distance exceeds 36864. The block is a five-stage pipeline
// (differences, squares, weighted sum, two levels of a minimum tree per stage) and
// takes one pixel every clock while the result channel is not stalled; the result
// is registered at the end of the last stage. A stall on the result channel holds
// every stage in place. PALETTE_ENTRIES limits the search to the first entries of
// the table; values above 16 behave as 16.
`default_nettype none

`include "nearest_palette_color_macros.svh"

module nearest_palette_color #(
	parameter int unsigned PALETTE_ENTRIES = npc_pkg::PALETTE_ENTRIES_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           pixel_valid,
	output logic                pixel_ready,
	input  wire npc_pkg::chan_t red,
	input  wire npc_pkg::chan_t green,
	input  wire npc_pkg::chan_t blue,
	output logic                result_valid,
	input  wire logic           result_ready,
	output npc_pkg::idx_t       color_index,
	output logic                poor_match
);

	localparam int unsigned LANES = (PALETTE_ENTRIES < npc_pkg::TABLE_SIZE)
		? PALETTE_ENTRIES : npc_pkg::TABLE_SIZE;
	localparam int unsigned NSTAGE = 5;

	logic                adv;
	logic [NSTAGE-1:0]   valid_q;
	npc_pkg::cand_t      cand [npc_pkg::TABLE_SIZE];
	npc_pkg::res_t       res;

	// whole pipeline moves when the output register is free or being read
	assign adv         = !result_valid || result_ready;
	assign pixel_ready = adv;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (adv) begin
			valid_q <= {valid_q[NSTAGE-2:0], pixel_valid};
		end
	end

	// one distance lane per compared entry, padding elsewhere
	for (genvar i = 0; i < npc_pkg::TABLE_SIZE; i++) begin : g_lane
		assign cand[i].idx = npc_pkg::IDX_W'(i);
		if (i < LANES) begin : g_used
			npc_dist_lane #(
				.ENTRY(i)
			) u_lane (
				.clk  (clk),
				.en   (adv),
				.red  (red),
				.green(green),
				.blue (blue),
				.wdist(cand[i].wdist)
			);
		end else begin : g_pad
			assign cand[i].wdist = npc_pkg::DIST_PAD;
		end
	end

	// minimum search and result register
	npc_min_tree u_tree (
		.clk (clk),
		.en  (adv),
		.cand(cand),
		.res (res)
	);

	assign result_valid = valid_q[NSTAGE-1];
	assign color_index  = res.idx;
	assign poor_match   = res.poor;

	// checks on the pipeline control
	`NPC_ASSERT_NEXT(a_stall_holds, clk, arst_n, !adv, $stable(valid_q))
	`NPC_ASSERT_NOW(a_empty_ready, clk, arst_n, !result_valid, pixel_ready)
	`NPC_ASSERT_NOW(a_fill_from_s4, clk, arst_n, $rose(result_valid), $past(valid_q[NSTAGE-2]))
	`NPC_ASSERT_NEXT(a_accept_enters, clk, arst_n, pixel_valid && pixel_ready, valid_q[0])

endmodule

`default_nettype wire
